/* hw/rtl/ebb_pkg.sv */
package ebb_pkg;

  localparam logic [2:0] CMD_PUT_POS = 3'd0;
  localparam logic [2:0] CMD_GET_POS = 3'd1;
  localparam logic [2:0] CMD_PUT_OFF = 3'd2;
  localparam logic [2:0] CMD_FLIP    = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;

  localparam int unsigned FIELD_W  = 13;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned CFG_W    = 13;
  localparam logic [CFG_W-1:0] CAP_RESET = 13'd4096;

  localparam logic [0:0] REG_BIG_ENDIAN = 1'b0;
  localparam logic [0:0] REG_CAPACITY   = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ebb_cmd_t;

  typedef struct packed {
    logic access;
    logic ok;
    logic last;
  } ebb_stat_t;

  function automatic logic [3:0] nbytes_f(input logic [1:0] size_code);
    logic [3:0] n;
    n = 4'd1 << size_code;
    return n;
  endfunction

endpackage

/* hw/rtl/ebb_ctrl.sv */
module ebb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ebb_pkg::ebb_stat_t stat,
  output ebb_pkg::ebb_cmd_t  cmd
);
  import ebb_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_XFER   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.access && stat.ok) state_nxt = S_XFER;
        else                        state_nxt = S_FINISH;
      end
      S_XFER: begin
        cmd.step = 1'b1;
        if (stat.last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish)    out_valid_nxt = 1'b1;
    else if (out_stall) out_valid_nxt = out_valid_r;
    else               out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/ebb_dpath.sv */
module ebb_dpath #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [0:0]                      cfg_index,
  input  logic [ebb_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic [2:0]                      in_command,
  input  logic [1:0]                      in_size_code,
  input  logic [ebb_pkg::VALUE_W-1:0]     in_write_value,
  input  logic [ebb_pkg::OFFSET_W-1:0]    in_at_offset,
  output logic                            out_status,
  output logic [ebb_pkg::VALUE_W-1:0]     out_read_value,
  output logic [ebb_pkg::FIELD_W-1:0]     out_position_now,
  output logic [ebb_pkg::FIELD_W-1:0]     out_limit_now,
  input  ebb_pkg::ebb_cmd_t               cmd,
  output ebb_pkg::ebb_stat_t              stat
);
  import ebb_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned SW = ((PW > FIELD_W) ? PW : FIELD_W) + 1;

  logic [7:0]         mem [DEPTH];

  logic               big_endian_r;
  logic [CFG_W-1:0]   cap_r;
  logic [SW-1:0]      pos_r, limit_r;

  logic [2:0]         command_r;
  logic [1:0]         size_r;
  logic [VALUE_W-1:0] wval_r;
  logic [OFFSET_W-1:0] offset_r;
  logic [2:0]         idx_r;
  logic [VALUE_W-1:0] acc_r;
  logic [7:0]         rd_data_r;
  logic               rd_pend_r;
  logic [2:0]         rd_lane_r;

  logic               status_r;
  logic [VALUE_W-1:0] rval_r;
  logic [FIELD_W-1:0] pos_out_r, limit_out_r;

  logic [3:0]         nbytes;
  logic [SW-1:0]      n_ext, cap, pos_end, off_end, base, addr_sum;
  logic [SW-1:0]      pos_nxt, limit_nxt;
  logic [2:0]         lane;
  logic [AW-1:0]      addr;
  logic               is_put, is_get, ok;

  assign nbytes  = nbytes_f(size_r);
  assign n_ext   = SW'(nbytes);
  assign cap     = (SW'(cap_r) > SW'(DEPTH)) ? SW'(DEPTH) : SW'(cap_r);
  assign pos_end = pos_r + n_ext;
  assign off_end = SW'(offset_r) + n_ext;
  assign is_put  = (command_r == CMD_PUT_POS) || (command_r == CMD_PUT_OFF);
  assign is_get  = (command_r == CMD_GET_POS);

  always_comb begin
    case (command_r)
      CMD_PUT_POS: ok = (pos_end <= cap);
      CMD_GET_POS: ok = (pos_end <= limit_r) && (pos_end <= SW'(DEPTH));
      CMD_PUT_OFF: ok = (off_end <= cap);
      CMD_FLIP:    ok = 1'b1;
      CMD_CLEAR:   ok = 1'b1;
      default:     ok = 1'b0;
    endcase
  end

  assign stat.access = is_put || is_get;
  assign stat.ok     = ok;
  assign stat.last   = ({1'b0, idx_r} == (nbytes - 4'd1));

  assign base     = (command_r == CMD_PUT_OFF) ? SW'(offset_r) : pos_r;
  assign addr_sum = base + SW'(idx_r);
  assign addr     = addr_sum[AW-1:0];
  assign lane     = big_endian_r ? 3'(nbytes - 4'd1 - {1'b0, idx_r}) : idx_r;

  always_comb begin
    pos_nxt   = pos_r;
    limit_nxt = limit_r;
    if (ok) begin
      case (command_r)
        CMD_PUT_POS: pos_nxt = pos_end;
        CMD_GET_POS: pos_nxt = pos_end;
        CMD_FLIP: begin
          limit_nxt = pos_r;
          pos_nxt   = '0;
        end
        CMD_CLEAR:   pos_nxt = '0;
        default:     pos_nxt = pos_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && is_put) mem[addr] <= wval_r[{lane, 3'b000} +: 8];
    rd_data_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b0;
      cap_r        <= CAP_RESET;
      pos_r        <= '0;
      limit_r      <= SW'(DEPTH);
      rd_pend_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BIG_ENDIAN: big_endian_r <= cfg_wdata[0];
          REG_CAPACITY:   cap_r        <= cfg_wdata;
          default:        cap_r        <= cap_r;
        endcase
      end
      if (cmd.finish) begin
        pos_r   <= pos_nxt;
        limit_r <= limit_nxt;
      end
      rd_pend_r <= cmd.step && is_get;
    end
  end

  always_ff @(posedge clk) begin
    rd_lane_r <= lane;
    if (cmd.load) begin
      command_r <= in_command;
      size_r    <= in_size_code;
      wval_r    <= in_write_value;
      offset_r  <= in_at_offset;
      idx_r     <= '0;
      acc_r     <= '0;
    end else begin
      if (cmd.step) idx_r <= idx_r + 3'd1;
      if (rd_pend_r) acc_r[{rd_lane_r, 3'b000} +: 8] <= rd_data_r;
    end
    if (cmd.finish) begin
      status_r    <= !ok;
      rval_r      <= acc_r;
      pos_out_r   <= pos_nxt[FIELD_W-1:0];
      limit_out_r <= limit_nxt[FIELD_W-1:0];
    end
  end

  assign out_status       = status_r;
  assign out_read_value   = rval_r;
  assign out_position_now = pos_out_r;
  assign out_limit_now    = limit_out_r;

endmodule

/* hw/rtl/endian_byte_buffer_unit.sv */
// Endian byte buffer: a DEPTH-byte store with a position and a limit.
// Input channel (in_valid / in_stall) carries one command per transaction:
// put at position, get at position, put at offset, flip or clear, with a
// size code, a 64-bit value and a byte offset. Each transaction yields
// exactly one result transaction on out_valid / out_stall: status, read
// value, and the position and limit after the command.
// An accepted put or get passes a check state, one transfer step per
// byte, a drain state and a finish state, from which out_valid is
// registered; flip, clear or a rejected command goes from check to
// finish. The store has one byte port, so a value moves one byte at a
// time. One command is in work at a time; the next is accepted after the
// previous one finishes, even while its result waits. Configuration
// (cfg_we, cfg_index, cfg_wdata) is for the user to write only while idle;
// the unit does not enforce it. Index 0 selects big endian order, index 1
// sets the usable capacity. Reset (synchronous, rst_n low) sets position
// to 0, limit to DEPTH, little endian and capacity 4096; store contents
// are undefined until written. A stalled result holds; the unit then
// finishes the next command and waits until the output register frees.
module endian_byte_buffer_unit #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [ebb_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_command,
  input  logic [1:0]                  in_size_code,
  input  logic [ebb_pkg::VALUE_W-1:0] in_write_value,
  input  logic [ebb_pkg::OFFSET_W-1:0] in_at_offset,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_status,
  output logic [ebb_pkg::VALUE_W-1:0] out_read_value,
  output logic [ebb_pkg::FIELD_W-1:0] out_position_now,
  output logic [ebb_pkg::FIELD_W-1:0] out_limit_now
);
  import ebb_pkg::*;

  ebb_cmd_t  cmd;
  ebb_stat_t stat;

  ebb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ebb_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_command       (in_command),
    .in_size_code     (in_size_code),
    .in_write_value   (in_write_value),
    .in_at_offset     (in_at_offset),
    .out_status       (out_status),
    .out_read_value   (out_read_value),
    .out_position_now (out_position_now),
    .out_limit_now    (out_limit_now),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule
